// ===== design/sha1_pkg.sv =====
// shared types, constants and helper functions of the sha-1 hash engine
`default_nettype none

package sha1_pkg;

   localparam int unsigned BlockWords  = 16;
   localparam int unsigned RoundCount  = 80;
   localparam int unsigned DigestWords = 5;

   typedef logic [31:0] word_type;
   typedef logic [6:0]  round_idx_type;
   typedef logic [3:0]  word_pos_type;
   typedef logic [63:0] bit_len_type;
   typedef logic [2:0]  byte_cnt_type;
   typedef logic [2:0]  emit_cnt_type;

   // five working variables a through e, also used for the chaining value
   typedef struct packed {
      word_type a;
      word_type b;
      word_type c;
      word_type d;
      word_type e;
   } vars_type;

   // control from the sequencer to the message window
   typedef struct packed {
      logic push;
      logic step;
   } msg_ctrl_type;

   // round constants
   localparam word_type K0 = 32'h5A82_7999;
   localparam word_type K1 = 32'h6ED9_EBA1;
   localparam word_type K2 = 32'h8F1B_BCDC;
   localparam word_type K3 = 32'hCA62_C1D6;

   // round phase boundaries
   localparam round_idx_type Phase1Start = 7'd20;
   localparam round_idx_type Phase2Start = 7'd40;
   localparam round_idx_type Phase3Start = 7'd60;
   localparam round_idx_type LastRound   = round_idx_type'(RoundCount - 1);

   // initial hash value
   localparam vars_type IvVars = {32'h6745_2301, 32'hEFCD_AB89, 32'h98BA_DCFE,
                                  32'h1032_5476, 32'hC3D2_E1F0};

   localparam word_type     PadMarker  = 32'h8000_0000;
   localparam byte_cnt_type FullBytes  = 3'd4;
   localparam word_pos_type LastPos    = word_pos_type'(BlockWords - 1);
   localparam word_pos_type LenHiPos   = word_pos_type'(BlockWords - 2);
   localparam emit_cnt_type LastDigest = emit_cnt_type'(DigestWords - 1);

   // rotate left by a constant amount
   function automatic word_type rotl(word_type x, int unsigned n);
      return (x << n) | (x >> (32 - n));
   endfunction

   // keep the valid leading bytes and place the 0x80 pad byte after them; a full word passes unchanged
   function automatic word_type pad_last_word(word_type data, byte_cnt_type nbytes);
      word_type res;
      case (nbytes)
         3'd0:    res = PadMarker;
         3'd1:    res = {data[31:24], 8'h80, 16'h0000};
         3'd2:    res = {data[31:16], 8'h80, 8'h00};
         3'd3:    res = {data[31:8], 8'h80};
         default: res = data;
      endcase
      return res;
   endfunction

endpackage

`default_nettype wire

// ===== design/sha1_round.sv =====
// one sha-1 compression round, shared over all 80 rounds
`default_nettype none

module sha1_round (
   input  sha1_pkg::vars_type      cur_vars,
   input  sha1_pkg::round_idx_type round_idx,
   input  sha1_pkg::word_type      sched_word,
   output sha1_pkg::vars_type      next_vars
);
   import sha1_pkg::*;

   word_type f_val;
   word_type k_val;
   word_type sum;

   // round function and constant by phase
   always_comb begin
      if (round_idx < Phase1Start) begin
         f_val = (cur_vars.b & cur_vars.c) | (~cur_vars.b & cur_vars.d);
         k_val = K0;
      end else if (round_idx < Phase2Start) begin
         f_val = cur_vars.b ^ cur_vars.c ^ cur_vars.d;
         k_val = K1;
      end else if (round_idx < Phase3Start) begin
         f_val = (cur_vars.b & cur_vars.c) | (cur_vars.b & cur_vars.d) |
                 (cur_vars.c & cur_vars.d);
         k_val = K2;
      end else begin
         f_val = cur_vars.b ^ cur_vars.c ^ cur_vars.d;
         k_val = K3;
      end
   end

   // five-operand add and variable rotation
   assign sum = rotl(cur_vars.a, 5) + f_val + cur_vars.e + sched_word + k_val;

   assign next_vars = {sum, cur_vars.a, rotl(cur_vars.b, 30), cur_vars.c, cur_vars.d};

endmodule

`default_nettype wire

// ===== design/sha1_msg.sv =====
// 16-word message window: loads block words and expands the rolling schedule
`default_nettype none

module sha1_msg (
   input  logic                   clock,
   input  sha1_pkg::msg_ctrl_type ctrl,
   input  sha1_pkg::word_type     push_word,
   output sha1_pkg::word_type     sched_word
);
   import sha1_pkg::*;

   word_type window_ff [BlockWords];
   word_type window_in [BlockWords];
   word_type expanded;

   // next schedule word from fixed taps of the window
   assign expanded = rotl(window_ff[13] ^ window_ff[8] ^ window_ff[2] ^ window_ff[0], 1);

   // shift on a pushed word or on a round step
   always_comb begin
      window_in = window_ff;
      if (ctrl.push || ctrl.step) begin
         for (int i = 0; i < BlockWords - 1; i++) begin
            window_in[i] = window_ff[i + 1];
         end
         window_in[BlockWords - 1] = ctrl.push ? push_word : expanded;
      end
   end

   always_ff @(posedge clock) begin
      window_ff <= window_in;
   end

   assign sched_word = window_ff[0];

endmodule

`default_nettype wire

// ===== design/sha1_hash_engine_top.sv =====
// SHA-1 hash engine: message word intake, padding sequencer and digest output.
// Each message word is shifted into a 16-word window. When the window fills,
// the single round unit runs the 80 compression rounds at one round per cycle,
// then the update state adds the result into the chaining value; the input is
// not ready while the rounds and the update run. On a word marked last the
// engine appends the pad byte, zero fill and the 64-bit bit length one word per
// cycle except while a full window is compressed, compressing one or two more
// blocks as needed, then presents the five digest words H0 to H4, one per
// accepted output transfer, and is ready for a new message after the fifth.
`default_nettype none

module sha1_hash_engine_top (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [31:0] req_data_word,
   input  logic [2:0]  req_valid_bytes,
   input  logic        req_last_word,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [31:0] rsp_digest_word,
   output logic        rsp_digest_last
);
   import sha1_pkg::*;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_PAD,
      ST_ROUND,
      ST_UPDATE,
      ST_EMIT
   } state_type;

   state_type     state_ff, state_in;
   vars_type      chain_ff, chain_in;
   vars_type      vars_ff, vars_in;
   bit_len_type   bit_len_ff, bit_len_in;
   word_pos_type  word_pos_ff, word_pos_in;
   round_idx_type round_ff, round_in;
   emit_cnt_type  emit_cnt_ff, emit_cnt_in;
   logic          pad_ff, pad_in;
   logic          marker_ff, marker_in;
   logic          len_hi_ff, len_hi_in;
   logic          len_done_ff, len_done_in;

   msg_ctrl_type  msg_ctrl;
   word_type      push_word;
   word_type      sched_word;
   vars_type      next_vars;
   byte_cnt_type  n_sat;

   sha1_msg u_msg (
      .clock      (clock),
      .ctrl       (msg_ctrl),
      .push_word  (push_word),
      .sched_word (sched_word)
   );

   sha1_round u_round (
      .cur_vars   (vars_ff),
      .round_idx  (round_ff),
      .sched_word (sched_word),
      .next_vars  (next_vars)
   );

   // byte count above four counts as a full word
   assign n_sat = (req_valid_bytes > FullBytes) ? FullBytes : req_valid_bytes;

   // sequencer next state
   always_comb begin
      state_in    = state_ff;
      chain_in    = chain_ff;
      vars_in     = vars_ff;
      bit_len_in  = bit_len_ff;
      word_pos_in = word_pos_ff;
      round_in    = round_ff;
      emit_cnt_in = emit_cnt_ff;
      pad_in      = pad_ff;
      marker_in   = marker_ff;
      len_hi_in   = len_hi_ff;
      len_done_in = len_done_ff;
      msg_ctrl    = '0;
      push_word   = '0;

      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               msg_ctrl.push = 1'b1;
               if (!req_last_word) begin
                  push_word  = req_data_word;
                  bit_len_in = bit_len_ff + 64'd32;
               end else begin
                  push_word   = pad_last_word(req_data_word, n_sat);
                  bit_len_in  = bit_len_ff + {58'b0, n_sat, 3'b000};
                  pad_in      = 1'b1;
                  marker_in   = (n_sat == FullBytes);
                  len_hi_in   = 1'b0;
                  len_done_in = 1'b0;
                  state_in    = ST_PAD;
               end
            end
         end
         ST_PAD: begin
            msg_ctrl.push = 1'b1;
            if (marker_ff) begin
               push_word = PadMarker;
               marker_in = 1'b0;
            end else if (len_hi_ff) begin
               push_word   = bit_len_ff[31:0];
               len_done_in = 1'b1;
            end else if (word_pos_ff == LenHiPos) begin
               push_word = bit_len_ff[63:32];
               len_hi_in = 1'b1;
            end else begin
               push_word = '0;
            end
         end
         ST_ROUND: begin
            msg_ctrl.step = 1'b1;
            vars_in       = next_vars;
            round_in      = round_ff + 7'd1;
            if (round_ff == LastRound) begin
               state_in = ST_UPDATE;
            end
         end
         ST_UPDATE: begin
            chain_in.a = chain_ff.a + vars_ff.a;
            chain_in.b = chain_ff.b + vars_ff.b;
            chain_in.c = chain_ff.c + vars_ff.c;
            chain_in.d = chain_ff.d + vars_ff.d;
            chain_in.e = chain_ff.e + vars_ff.e;
            if (len_done_ff) begin
               emit_cnt_in = '0;
               state_in    = ST_EMIT;
            end else if (pad_ff) begin
               state_in = ST_PAD;
            end else begin
               state_in = ST_IDLE;
            end
         end
         ST_EMIT: begin
            if (rsp_ready) begin
               emit_cnt_in = emit_cnt_ff + 3'd1;
               chain_in    = {chain_ff.b, chain_ff.c, chain_ff.d, chain_ff.e, chain_ff.e};
               if (emit_cnt_ff == LastDigest) begin
                  chain_in    = IvVars;
                  bit_len_in  = '0;
                  word_pos_in = '0;
                  pad_in      = 1'b0;
                  len_hi_in   = 1'b0;
                  len_done_in = 1'b0;
                  state_in    = ST_IDLE;
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase

      // every pushed word advances the slot; a full window starts compression
      if (msg_ctrl.push) begin
         word_pos_in = word_pos_ff + 4'd1;
         if (word_pos_ff == LastPos) begin
            vars_in  = chain_ff;
            round_in = '0;
            state_in = ST_ROUND;
         end
      end
   end

   // state and registered values
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff    <= ST_IDLE;
         chain_ff    <= IvVars;
         vars_ff     <= '0;
         bit_len_ff  <= '0;
         word_pos_ff <= '0;
         round_ff    <= '0;
         emit_cnt_ff <= '0;
         pad_ff      <= 1'b0;
         marker_ff   <= 1'b0;
         len_hi_ff   <= 1'b0;
         len_done_ff <= 1'b0;
      end else begin
         state_ff    <= state_in;
         chain_ff    <= chain_in;
         vars_ff     <= vars_in;
         bit_len_ff  <= bit_len_in;
         word_pos_ff <= word_pos_in;
         round_ff    <= round_in;
         emit_cnt_ff <= emit_cnt_in;
         pad_ff      <= pad_in;
         marker_ff   <= marker_in;
         len_hi_ff   <= len_hi_in;
         len_done_ff <= len_done_in;
      end
   end

   // handshake and digest output
   assign req_ready       = (state_ff == ST_IDLE);
   assign rsp_valid       = (state_ff == ST_EMIT);
   assign rsp_digest_word = chain_ff.a;
   assign rsp_digest_last = (emit_cnt_ff == LastDigest);

`ifndef SYNTHESIS
   // intake and digest output never overlap
   a_no_overlap: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !req_ready)
      else $error("input ready while digest words pending");

   // a last word always starts padding work
   a_last_busy: assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready && req_last_word) |=> !req_ready)
      else $error("input ready right after last word");

   // compression only runs on a complete window
   a_round_pos: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_ROUND || state_ff == ST_UPDATE) |-> (word_pos_ff == '0))
      else $error("compression with a partial window");

   // final digest word ends the output run
   a_digest_end: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_ready && rsp_digest_last) |=> !rsp_valid)
      else $error("digest words continue past the fifth");
`endif

endmodule

`default_nettype wire
